>>> design/usb_hotplug_presence_tracker_assert.svh
// ----------------------------------------------------------------------------
// usb hotplug presence tracker assertion macros
// shared concurrent assertion forms used by the tracker modules
// ----------------------------------------------------------------------------
`ifndef USB_HOTPLUG_PRESENCE_TRACKER_ASSERT_SVH
`define USB_HOTPLUG_PRESENCE_TRACKER_ASSERT_SVH

// same-cycle implication
`define UHPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UHPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/uhpt_pkg.sv
// ----------------------------------------------------------------------------
// uhpt_pkg
// types and constants shared by the hotplug presence tracker modules
// ----------------------------------------------------------------------------
package uhpt_pkg;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_EDGE  = 3'd1,
        OP_PING  = 3'd2,
        OP_START = 3'd3,
        OP_STOP  = 3'd4
    } t_op;

    localparam logic [1:0] CFG_STABLE   = 2'd0;
    localparam logic [1:0] CFG_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_LIMIT    = 2'd2;

    localparam logic [7:0]  DEF_STABLE   = 8'd50;
    localparam logic [15:0] DEF_INTERVAL = 16'd200;
    localparam logic [7:0]  DEF_LIMIT    = 8'd2;
    localparam logic [15:0] START_DELAY  = 16'd3;

    localparam logic EVT_CABLE = 1'b0;
    localparam logic EVT_USB   = 1'b1;

    localparam int EVQ_DEPTH = 4;
    localparam int EVQ_AW    = $clog2(EVQ_DEPTH);

    typedef struct packed {
        logic [7:0]  stable_samples;
        logic [15:0] keepalive_interval;
        logic [7:0]  keepalive_limit;
    } t_cfg;

    typedef struct packed {
        logic cable_chg;
        logic usb_chg;
        logic cable_up;
        logic usb_up;
        logic probe_ran;
    } t_chg;

    typedef struct packed {
        logic event_kind;
        logic is_online;
        logic phy_was_touched;
        logic last_event;
    } t_event;

endpackage

>>> design/uhpt_core.sv
// ----------------------------------------------------------------------------
// uhpt_core
// presence state, debounce and keep-alive update for one transaction
// ----------------------------------------------------------------------------
`include "usb_hotplug_presence_tracker_assert.svh"

module uhpt_core
    import uhpt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [2:0] i_operation,
    input  logic       i_pin_level,
    input  logic       i_bus_activity,
    input  logic       i_frame_advanced,
    input  t_cfg       i_cfg,
    output t_chg       o_chg
);

    logic        r_cable_up, n_cable_up;
    logic        r_usb_up, n_usb_up;
    logic        r_probe_ran, n_probe_ran;
    logic        r_detect_armed, n_detect_armed;
    logic        r_previous_pin, n_previous_pin;
    logic [7:0]  r_stable_run, n_stable_run;
    logic        r_alive_enabled, n_alive_enabled;
    logic        r_alive_expired, n_alive_expired;
    logic [7:0]  r_alive_countdown, n_alive_countdown;
    logic [15:0] r_interval_ticks, n_interval_ticks;

    logic [7:0]  eff_limit;
    logic [15:0] eff_interval;
    logic [7:0]  cd_dec;
    logic        cable_chg, usb_chg;

    assign eff_limit    = (i_cfg.keepalive_limit != '0) ? i_cfg.keepalive_limit : DEF_LIMIT;
    assign eff_interval = (i_cfg.keepalive_interval != '0) ? i_cfg.keepalive_interval
                                                           : DEF_INTERVAL;

    always_comb begin
        n_cable_up        = r_cable_up;
        n_usb_up          = r_usb_up;
        n_probe_ran       = r_probe_ran;
        n_detect_armed    = r_detect_armed;
        n_previous_pin    = r_previous_pin;
        n_stable_run      = r_stable_run;
        n_alive_enabled   = r_alive_enabled;
        n_alive_expired   = r_alive_expired;
        n_alive_countdown = r_alive_countdown;
        n_interval_ticks  = r_interval_ticks;
        cable_chg         = 1'b0;
        usb_chg           = 1'b0;
        cd_dec            = (r_alive_countdown != '0) ? r_alive_countdown - 8'd1 : '0;

        case (i_operation)
            OP_TICK: begin
                // keep-alive timer
                if (r_interval_ticks != '0) begin
                    n_interval_ticks = r_interval_ticks - 16'd1;
                    if (n_interval_ticks == '0) begin
                        if (r_alive_enabled) begin
                            n_alive_countdown = cd_dec;
                            if (cd_dec == '0) begin
                                if (i_frame_advanced) begin
                                    n_alive_countdown = eff_limit;
                                end else begin
                                    n_alive_expired = 1'b1;
                                    n_usb_up        = 1'b0;
                                    usb_chg         = 1'b1;
                                end
                            end
                        end
                        if (r_alive_enabled && !n_alive_expired) begin
                            n_interval_ticks = eff_interval;
                        end
                    end
                end
                // debounce and detection
                if (r_detect_armed) begin
                    if (r_stable_run == '0 || i_pin_level != r_previous_pin) begin
                        n_previous_pin = i_pin_level;
                        n_stable_run   = 8'd1;
                    end else if (r_stable_run != 8'hFF) begin
                        n_stable_run = r_stable_run + 8'd1;
                    end
                    if (n_stable_run >= i_cfg.stable_samples) begin
                        cable_chg   = (r_cable_up != i_pin_level);
                        n_cable_up  = i_pin_level;
                        n_probe_ran = i_pin_level;
                        if (!i_pin_level) begin
                            n_alive_enabled = 1'b0;
                        end
                        if (i_pin_level && i_bus_activity) begin
                            if (!n_usb_up) begin
                                usb_chg = 1'b1;
                            end
                            n_usb_up = 1'b1;
                        end else begin
                            n_alive_enabled = 1'b0;
                            if (n_usb_up) begin
                                usb_chg = 1'b1;
                            end
                            n_usb_up = 1'b0;
                        end
                        n_detect_armed = 1'b0;
                        n_stable_run   = '0;
                    end
                end
            end
            OP_EDGE: begin
                n_detect_armed = 1'b1;
                n_stable_run   = '0;
            end
            OP_PING: begin
                n_alive_countdown = eff_limit;
                if (r_alive_expired) begin
                    n_alive_expired  = 1'b0;
                    n_alive_enabled  = 1'b1;
                    n_interval_ticks = START_DELAY;
                end
            end
            OP_START: begin
                if (!r_alive_enabled) begin
                    n_alive_enabled   = 1'b1;
                    n_alive_countdown = eff_limit;
                    n_interval_ticks  = START_DELAY;
                end
            end
            OP_STOP: begin
                n_alive_enabled = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cable_up        <= 1'b0;
            r_usb_up          <= 1'b0;
            r_probe_ran       <= 1'b0;
            r_detect_armed    <= 1'b0;
            r_previous_pin    <= 1'b0;
            r_stable_run      <= '0;
            r_alive_enabled   <= 1'b0;
            r_alive_expired   <= 1'b0;
            r_alive_countdown <= '0;
            r_interval_ticks  <= '0;
        end else if (i_valid) begin
            r_cable_up        <= n_cable_up;
            r_usb_up          <= n_usb_up;
            r_probe_ran       <= n_probe_ran;
            r_detect_armed    <= n_detect_armed;
            r_previous_pin    <= n_previous_pin;
            r_stable_run      <= n_stable_run;
            r_alive_enabled   <= n_alive_enabled;
            r_alive_expired   <= n_alive_expired;
            r_alive_countdown <= n_alive_countdown;
            r_interval_ticks  <= n_interval_ticks;
        end
    end

    assign o_chg.cable_chg = cable_chg;
    assign o_chg.usb_chg   = usb_chg;
    assign o_chg.cable_up  = n_cable_up;
    assign o_chg.usb_up    = n_usb_up;
    assign o_chg.probe_ran = n_probe_ran;

    `UHPT_ASSERT_IMP(a_probe_follows_cable, i_clk, i_rst_n, 1'b1,
        r_probe_ran == r_cable_up, "probe flag differs from cable state")
    `UHPT_ASSERT_IMP(a_expiry_needs_enable, i_clk, i_rst_n,
        $past(i_rst_n) && $rose(r_alive_expired), $past(r_alive_enabled),
        "keep-alive expired while disabled")
    `UHPT_ASSERT_IMP(a_revive_enables, i_clk, i_rst_n,
        $past(i_rst_n) && $fell(r_alive_expired), r_alive_enabled,
        "keep-alive revived without enable")

endmodule

>>> design/uhpt_evq.sv
// ----------------------------------------------------------------------------
// uhpt_evq
// event queue: splits state changes into events and holds them for output
// ----------------------------------------------------------------------------
`include "usb_hotplug_presence_tracker_assert.svh"

module uhpt_evq
    import uhpt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_chg   i_chg,
    output logic   o_room,
    output logic   o_valid,
    input  logic   i_stall,
    output t_event o_event
);

    localparam logic [EVQ_AW:0] ROOM_LIMIT = (EVQ_AW + 1)'(EVQ_DEPTH - 2);

    t_event              r_mem [EVQ_DEPTH];
    logic [EVQ_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [EVQ_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [EVQ_AW:0]     r_count, n_count;

    t_event              ev_cable, ev_usb, ev_first;
    logic [1:0]          push_n;
    logic                pop;

    assign o_room = (r_count <= ROOM_LIMIT);
    assign pop    = o_valid && !i_stall;

    always_comb begin
        ev_cable.event_kind      = EVT_CABLE;
        ev_cable.is_online       = i_chg.cable_up;
        ev_cable.phy_was_touched = 1'b0;
        ev_cable.last_event      = !i_chg.usb_chg;
        ev_usb.event_kind        = EVT_USB;
        ev_usb.is_online         = i_chg.usb_up;
        ev_usb.phy_was_touched   = i_chg.probe_ran;
        ev_usb.last_event        = 1'b1;
        ev_first                 = i_chg.cable_chg ? ev_cable : ev_usb;
        push_n = i_push ? ({1'b0, i_chg.cable_chg} + {1'b0, i_chg.usb_chg}) : 2'd0;
        n_wr_ptr = r_wr_ptr + EVQ_AW'(push_n);
        n_rd_ptr = r_rd_ptr + EVQ_AW'(pop);
        n_count  = r_count + (EVQ_AW + 1)'(push_n) - (EVQ_AW + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= ev_first;
        end
        if (push_n == 2'd2) begin
            r_mem[r_wr_ptr + EVQ_AW'(1)] <= ev_usb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_event = r_mem[r_rd_ptr];

    `UHPT_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= (EVQ_AW + 1)'(EVQ_DEPTH), "event queue overflow")
    `UHPT_ASSERT_IMP(a_empty_ptrs, i_clk, i_rst_n, r_count == '0,
        r_wr_ptr == r_rd_ptr, "empty queue with unequal pointers")
    `UHPT_ASSERT_NXT(a_push_fits, i_clk, i_rst_n, i_push && o_room,
        r_count <= (EVQ_AW + 1)'(EVQ_DEPTH), "push overran the queue")

endmodule

>>> design/usb_hotplug_presence_tracker.sv
// ----------------------------------------------------------------------------
// usb_hotplug_presence_tracker
// cable and usb presence tracking with debounce and keep-alive watchdog
// ----------------------------------------------------------------------------
// input channel: i_valid / o_stall with operation and tick samples; a
// transaction lands in an input register, is applied to the presence state
// once the queue has room, and its events (zero, one or two) go into a
// four-entry event queue.
// output channel: o_valid / i_stall, one event per transaction; last_event
// marks the final event of an input.
// config channel: i_cfg_valid / o_cfg_ready, always ready; index 0 stable
// samples, 1 keep-alive interval, 2 keep-alive limit, others ignored.
// throughput: one input per cycle while the queue has room for two events;
// the output side delivers one event per cycle while i_stall is low, so
// inputs with two events are paced by the output.
// a receiver stall holds the current event; once the queue holds more than
// two entries the input register stops draining and raises o_stall.
// reset clears all presence and keep-alive state, empties the queue and
// loads the register defaults.
// ----------------------------------------------------------------------------
module usb_hotplug_presence_tracker
    import uhpt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_operation,
    input  logic        i_pin_level,
    input  logic        i_bus_activity,
    input  logic        i_frame_advanced,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_event_kind,
    output logic        o_is_online,
    output logic        o_phy_was_touched,
    output logic        o_last_event,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic [2:0]  r_in_operation;
    logic        r_in_pin_level;
    logic        r_in_bus_activity;
    logic        r_in_frame_advanced;

    logic        room;
    logic        consume;
    logic        accept;
    t_chg        chg;
    t_event      event_out;

    assign o_cfg_ready = 1'b1;
    assign consume     = r_in_valid && room;
    assign o_stall     = r_in_valid && !room;
    assign accept      = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stable_samples     <= DEF_STABLE;
            r_cfg.keepalive_interval <= DEF_INTERVAL;
            r_cfg.keepalive_limit    <= DEF_LIMIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_STABLE:   r_cfg.stable_samples     <= i_cfg_data[7:0];
                CFG_INTERVAL: r_cfg.keepalive_interval <= i_cfg_data;
                CFG_LIMIT:    r_cfg.keepalive_limit    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_operation      <= i_operation;
            r_in_pin_level      <= i_pin_level;
            r_in_bus_activity   <= i_bus_activity;
            r_in_frame_advanced <= i_frame_advanced;
        end
    end

    uhpt_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (consume),
        .i_operation      (r_in_operation),
        .i_pin_level      (r_in_pin_level),
        .i_bus_activity   (r_in_bus_activity),
        .i_frame_advanced (r_in_frame_advanced),
        .i_cfg            (r_cfg),
        .o_chg            (chg)
    );

    uhpt_evq u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (consume),
        .i_chg   (chg),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_event (event_out)
    );

    assign o_event_kind      = event_out.event_kind;
    assign o_is_online       = event_out.is_online;
    assign o_phy_was_touched = event_out.phy_was_touched;
    assign o_last_event      = event_out.last_event;

endmodule
